### hdl/des_pkg.sv
// ----------------------------------------------------------------------------
// des_pkg
// Types, permutation tables, S-boxes and round helpers for the DES core.
// ----------------------------------------------------------------------------
`default_nettype none

package des_pkg;

   typedef struct packed {
      logic [31:0] left;
      logic [31:0] right;
   } half_pair_type;

   typedef enum logic {
      REG_CIPHER_KEY   = 1'b0,
      REG_DECRYPT_MODE = 1'b1
   } reg_index_type;

   localparam int ROUNDS = 16;

   localparam logic [6:0] IP_TBL [64] = '{
      7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
      7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
      7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
      7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
      7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
      7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
      7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
      7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
   };

   localparam logic [6:0] FP_TBL [64] = '{
      7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
      7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
      7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
      7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
      7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
      7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
      7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
      7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
   };

   localparam logic [5:0] E_TBL [48] = '{
      6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
      6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
      6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
      6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
   };

   localparam logic [5:0] P_TBL [32] = '{
      6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
      6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
      6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
      6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
   };

   localparam logic [6:0] PC1_TBL [56] = '{
      7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50, 7'd42, 7'd34,
      7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
      7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,
      7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
      7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
   };

   localparam logic [5:0] PC2_TBL [48] = '{
      6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
      6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
      6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
      6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
   };

   // total left rotation of C and D at each round
   localparam logic [4:0] KS_SHIFT_TBL [16] = '{
      5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
      5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28
   };

   localparam logic [3:0] SBOX_TBL [8][64] = '{
      '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
        4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7,
        4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
        4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8,
        4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
        4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0,
        4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
        4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13},
      '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
        4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10,
        4'd3,  4'd13, 4'd4,  4'd7,  4'd15, 4'd2,  4'd8,  4'd14,
        4'd12, 4'd0,  4'd1,  4'd10, 4'd6,  4'd9,  4'd11, 4'd5,
        4'd0,  4'd14, 4'd7,  4'd11, 4'd10, 4'd4,  4'd13, 4'd1,
        4'd5,  4'd8,  4'd12, 4'd6,  4'd9,  4'd3,  4'd2,  4'd15,
        4'd13, 4'd8,  4'd10, 4'd1,  4'd3,  4'd15, 4'd4,  4'd2,
        4'd11, 4'd6,  4'd7,  4'd12, 4'd0,  4'd5,  4'd14, 4'd9},
      '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
        4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8,
        4'd13, 4'd7,  4'd0,  4'd9,  4'd3,  4'd4,  4'd6,  4'd10,
        4'd2,  4'd8,  4'd5,  4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
        4'd13, 4'd6,  4'd4,  4'd9,  4'd8,  4'd15, 4'd3,  4'd0,
        4'd11, 4'd1,  4'd2,  4'd12, 4'd5,  4'd10, 4'd14, 4'd7,
        4'd1,  4'd10, 4'd13, 4'd0,  4'd6,  4'd9,  4'd8,  4'd7,
        4'd4,  4'd15, 4'd14, 4'd3,  4'd11, 4'd5,  4'd2,  4'd12},
      '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
        4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15,
        4'd13, 4'd8,  4'd11, 4'd5,  4'd6,  4'd15, 4'd0,  4'd3,
        4'd4,  4'd7,  4'd2,  4'd12, 4'd1,  4'd10, 4'd14, 4'd9,
        4'd10, 4'd6,  4'd9,  4'd0,  4'd12, 4'd11, 4'd7,  4'd13,
        4'd15, 4'd1,  4'd3,  4'd14, 4'd5,  4'd2,  4'd8,  4'd4,
        4'd3,  4'd15, 4'd0,  4'd6,  4'd10, 4'd1,  4'd13, 4'd8,
        4'd9,  4'd4,  4'd5,  4'd11, 4'd12, 4'd7,  4'd2,  4'd14},
      '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
        4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9,
        4'd14, 4'd11, 4'd2,  4'd12, 4'd4,  4'd7,  4'd13, 4'd1,
        4'd5,  4'd0,  4'd15, 4'd10, 4'd3,  4'd9,  4'd8,  4'd6,
        4'd4,  4'd2,  4'd1,  4'd11, 4'd10, 4'd13, 4'd7,  4'd8,
        4'd15, 4'd9,  4'd12, 4'd5,  4'd6,  4'd3,  4'd0,  4'd14,
        4'd11, 4'd8,  4'd12, 4'd7,  4'd1,  4'd14, 4'd2,  4'd13,
        4'd6,  4'd15, 4'd0,  4'd9,  4'd10, 4'd4,  4'd5,  4'd3},
      '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
        4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11,
        4'd10, 4'd15, 4'd4,  4'd2,  4'd7,  4'd12, 4'd9,  4'd5,
        4'd6,  4'd1,  4'd13, 4'd14, 4'd0,  4'd11, 4'd3,  4'd8,
        4'd9,  4'd14, 4'd15, 4'd5,  4'd2,  4'd8,  4'd12, 4'd3,
        4'd7,  4'd0,  4'd4,  4'd10, 4'd1,  4'd13, 4'd11, 4'd6,
        4'd4,  4'd3,  4'd2,  4'd12, 4'd9,  4'd5,  4'd15, 4'd10,
        4'd11, 4'd14, 4'd1,  4'd7,  4'd6,  4'd0,  4'd8,  4'd13},
      '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
        4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1,
        4'd13, 4'd0,  4'd11, 4'd7,  4'd4,  4'd9,  4'd1,  4'd10,
        4'd14, 4'd3,  4'd5,  4'd12, 4'd2,  4'd15, 4'd8,  4'd6,
        4'd1,  4'd4,  4'd11, 4'd13, 4'd12, 4'd3,  4'd7,  4'd14,
        4'd10, 4'd15, 4'd6,  4'd8,  4'd0,  4'd5,  4'd9,  4'd2,
        4'd6,  4'd11, 4'd13, 4'd8,  4'd1,  4'd4,  4'd10, 4'd7,
        4'd9,  4'd5,  4'd0,  4'd15, 4'd14, 4'd2,  4'd3,  4'd12},
      '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
        4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7,
        4'd1,  4'd15, 4'd13, 4'd8,  4'd10, 4'd3,  4'd7,  4'd4,
        4'd12, 4'd5,  4'd6,  4'd11, 4'd0,  4'd14, 4'd9,  4'd2,
        4'd7,  4'd11, 4'd4,  4'd1,  4'd9,  4'd12, 4'd14, 4'd2,
        4'd0,  4'd6,  4'd10, 4'd13, 4'd15, 4'd3,  4'd5,  4'd8,
        4'd2,  4'd1,  4'd14, 4'd7,  4'd4,  4'd10, 4'd8,  4'd13,
        4'd15, 4'd12, 4'd9,  4'd0,  4'd3,  4'd5,  4'd6,  4'd11}
   };

   // table entries count from 1 at the MSB
   function automatic logic [63:0] initial_perm(logic [63:0] x);
      logic [63:0] y;
      for (int i = 0; i < 64; i++) begin
         y[63 - i] = x[6'(64 - int'(IP_TBL[i]))];
      end
      return y;
   endfunction

   function automatic logic [63:0] final_perm(logic [63:0] x);
      logic [63:0] y;
      for (int i = 0; i < 64; i++) begin
         y[63 - i] = x[6'(64 - int'(FP_TBL[i]))];
      end
      return y;
   endfunction

   function automatic logic [27:0] rot28(logic [27:0] v, logic [4:0] n);
      logic [55:0] dbl;
      dbl = {v, v};
      return dbl[6'(55 - int'(n)) -: 28];
   endfunction

   // round key after the given total rotation
   function automatic logic [47:0] subkey(logic [63:0] key, logic [4:0] shift);
      logic [55:0] cd;
      logic [55:0] cd_rot;
      logic [47:0] k;
      for (int i = 0; i < 56; i++) begin
         cd[55 - i] = key[6'(64 - int'(PC1_TBL[i]))];
      end
      cd_rot = {rot28(cd[55:28], shift), rot28(cd[27:0], shift)};
      for (int i = 0; i < 48; i++) begin
         k[47 - i] = cd_rot[6'(56 - int'(PC2_TBL[i]))];
      end
      return k;
   endfunction

   function automatic logic [31:0] feistel(logic [31:0] r, logic [47:0] k);
      logic [47:0] x;
      logic [5:0]  six;
      logic [31:0] s;
      logic [31:0] y;
      for (int i = 0; i < 48; i++) begin
         x[47 - i] = r[5'(32 - int'(E_TBL[i]))];
      end
      x = x ^ k;
      for (int b = 0; b < 8; b++) begin
         six = x[47 - 6 * b -: 6];
         s[31 - 4 * b -: 4] = SBOX_TBL[b][{six[5], six[0], six[4:1]}];
      end
      for (int i = 0; i < 32; i++) begin
         y[31 - i] = s[5'(32 - int'(P_TBL[i]))];
      end
      return y;
   endfunction

endpackage

`default_nettype wire

### hdl/des_round.sv
// ----------------------------------------------------------------------------
// des_round
// One Feistel round as a pipeline stage with its own valid bit and ready.
// ----------------------------------------------------------------------------
`default_nettype none

module des_round (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output      logic                  in_ready,
   input  wire des_pkg::half_pair_type in_half,
   input  wire logic [47:0]           round_key,
   output      logic                  out_valid,
   input  wire logic                  out_ready,
   output      des_pkg::half_pair_type out_half
);

   logic                   valid_ff;
   logic                   valid_in;
   des_pkg::half_pair_type half_ff;
   des_pkg::half_pair_type half_in;

   // stage takes an item when empty or when its item leaves this cycle
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_half  = half_ff;

   always_comb begin
      valid_in = valid_ff;
      half_in  = half_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
      if (in_valid && in_ready) begin
         half_in.left  = in_half.right;
         half_in.right = in_half.left ^ des_pkg::feistel(in_half.right, round_key);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      half_ff <= half_in;
   end

endmodule

`default_nettype wire

### hdl/des_block_cipher.sv
// ----------------------------------------------------------------------------
// des_block_cipher: single DES, sixteen-stage round pipeline.
// Each stage registers one round, so a result is valid after all sixteen.
// Throughput: one item per cycle while rsp_ready is high; a stalled result
// holds only the stages behind it, earlier bubbles are still filled.
// Reset: clears all stage valid bits, the key to zero and the mode to encrypt.
// ----------------------------------------------------------------------------
`default_nettype none

module des_block_cipher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [63:0] req_data_block,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [63:0] rsp_result_block,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output      logic [63:0] csr_prdata,
   output      logic        csr_pready
);

   localparam int NR = des_pkg::ROUNDS;

   logic [63:0] key_ff;
   logic [63:0] key_in;
   logic        mode_ff;
   logic        mode_in;
   logic        csr_write;

   des_pkg::reg_index_type csr_index;

   logic [47:0]            sched_key [NR];
   logic [NR:0]            stage_valid;
   logic [NR:0]            stage_ready;
   des_pkg::half_pair_type stage_half [NR+1];
   logic [63:0]            ip_block;
   logic [63:0]            pre_out;

   // ---------------------------------------------------------------- config
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = des_pkg::reg_index_type'(csr_paddr[3]);

   always_comb begin
      key_in  = key_ff;
      mode_in = mode_ff;
      if (csr_write) begin
         unique case (csr_index)
            des_pkg::REG_CIPHER_KEY:   key_in  = csr_pwdata;
            des_pkg::REG_DECRYPT_MODE: mode_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         des_pkg::REG_CIPHER_KEY:   csr_prdata = key_ff;
         des_pkg::REG_DECRYPT_MODE: csr_prdata = {63'd0, mode_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= '0;
         mode_ff <= 1'b0;
      end else begin
         key_ff  <= key_in;
         mode_ff <= mode_in;
      end
   end

   // ------------------------------------------------------------- datapath
   assign ip_block            = des_pkg::initial_perm(req_data_block);
   assign stage_half[0].left  = ip_block[63:32];
   assign stage_half[0].right = ip_block[31:0];
   assign stage_valid[0]      = req_valid;
   assign req_ready           = stage_ready[0];
   assign stage_ready[NR]     = rsp_ready;

   for (genvar g = 0; g < NR; g++) begin : g_round
      logic [47:0] stage_key;

      // key schedule is pure wiring of the key register
      assign sched_key[g] = des_pkg::subkey(key_ff, des_pkg::KS_SHIFT_TBL[g]);
      assign stage_key    = mode_ff ? sched_key[NR - 1 - g] : sched_key[g];

      des_round u_round (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[g]),
         .in_ready  (stage_ready[g]),
         .in_half   (stage_half[g]),
         .round_key (stage_key),
         .out_valid (stage_valid[g+1]),
         .out_ready (stage_ready[g+1]),
         .out_half  (stage_half[g+1])
      );
   end

   // halves swap after the last round
   assign pre_out          = {stage_half[NR].right, stage_half[NR].left};
   assign rsp_result_block = des_pkg::final_perm(pre_out);
   assign rsp_valid        = stage_valid[NR];

`ifndef ASSERT_OFF
   a_full_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (&stage_valid[NR:1] && !rsp_ready) |-> !req_ready)
      else $error("full stalled pipeline still took an item");

   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !stage_valid[1] |-> req_ready)
      else $error("empty first stage refused an item");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> stage_valid[1])
      else $error("accepted item missing from first stage");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (stage_valid[NR:1] == '0))
      else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire
